// ----- sv/dsa_pkg.sv -----
package dsa_pkg;

   // Pool size and derived widths
   localparam int SLOT_COUNT = 4096;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SLOT_W     = 12;
   localparam int REL_W      = 16;

   // Request operation codes
   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   typedef enum logic [2:0] {
      ST_FROM_LIST   = 3'd0,
      ST_FRESH       = 3'd1,
      ST_EXISTING    = 3'd2,
      ST_FULL        = 3'd3,
      ST_NO_RESOURCE = 3'd4,
      ST_RELEASED    = 3'd5,
      ST_IGNORED     = 3'd6,
      ST_OVERFLOW    = 3'd7
   } status_type;

   // Registered result, in the cycle after the request transfer
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
      status_type        status;
   } rsp_type;

   // Fit a pool index onto the slot port: truncate or zero extend
   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ----- sv/dsa_ram.sv -----
module dsa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/dsa_ctrl.sv -----
module dsa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic                          req_has_resource,
   input  logic                          req_has_existing,
   input  logic [dsa_pkg::SLOT_W-1:0]    req_existing_index,
   input  logic [dsa_pkg::REL_W-1:0]     req_release_index,
   output logic                          ram_wr_en,
   output logic [dsa_pkg::IDX_W-1:0]     ram_wr_addr,
   output logic [dsa_pkg::IDX_W-1:0]     ram_wr_data,
   output logic                          ram_rd_en,
   output logic [dsa_pkg::IDX_W-1:0]     ram_rd_addr,
   output dsa_pkg::rsp_type              rsp
);

   localparam logic [dsa_pkg::CNT_W-1:0] CountFull = dsa_pkg::CNT_W'(dsa_pkg::SLOT_COUNT);
   localparam logic [dsa_pkg::IDX_W-1:0] LastPos   = dsa_pkg::IDX_W'(dsa_pkg::SLOT_COUNT - 1);
   localparam logic [dsa_pkg::REL_W:0]   RelLimit  = (dsa_pkg::REL_W + 1)'(dsa_pkg::SLOT_COUNT);

   logic                        busy_ff;
   logic [dsa_pkg::CNT_W-1:0]   fresh_count_ff, fresh_count_in;
   logic [dsa_pkg::IDX_W-1:0]   free_head_ff, free_head_in;
   logic [dsa_pkg::IDX_W-1:0]   free_tail_ff, free_tail_in;
   logic [dsa_pkg::CNT_W-1:0]   free_count_ff, free_count_in;
   dsa_pkg::rsp_type            rsp_ff, rsp_in;
   logic                        accept;
   logic                        push;
   logic                        pop;
   logic                        rel_in_range;

   assign accept       = start && !busy_ff;
   assign rel_in_range = {1'b0, req_release_index} < RelLimit;

   // Decide the request outcome and the next pointer values
   always_comb begin
      push           = 1'b0;
      pop            = 1'b0;
      fresh_count_in = fresh_count_ff;
      free_head_in   = free_head_ff;
      free_tail_in   = free_tail_ff;
      free_count_in  = free_count_ff;
      rsp_in.valid   = accept;
      rsp_in.slot    = '0;
      rsp_in.status  = dsa_pkg::ST_NO_RESOURCE;
      if (accept) begin
         if (req_operation == dsa_pkg::OP_RELEASE) begin
            priority if (!rel_in_range) begin
               rsp_in.status = dsa_pkg::ST_IGNORED;
            end else if (free_count_ff == CountFull) begin
               rsp_in.status = dsa_pkg::ST_OVERFLOW;
            end else begin
               push          = 1'b1;
               free_tail_in  = (free_tail_ff == LastPos) ? '0 : free_tail_ff + 1'b1;
               free_count_in = free_count_ff + 1'b1;
               rsp_in.status = dsa_pkg::ST_RELEASED;
            end
         end else begin
            priority if (!req_has_resource) begin
               rsp_in.status = dsa_pkg::ST_NO_RESOURCE;
            end else if (req_has_existing) begin
               rsp_in.slot   = req_existing_index;
               rsp_in.status = dsa_pkg::ST_EXISTING;
            end else if (free_count_ff != '0) begin
               // slot comes from the RAM read in the next cycle
               pop           = 1'b1;
               free_head_in  = (free_head_ff == LastPos) ? '0 : free_head_ff + 1'b1;
               free_count_in = free_count_ff - 1'b1;
               rsp_in.status = dsa_pkg::ST_FROM_LIST;
            end else if (fresh_count_ff < CountFull) begin
               fresh_count_in = fresh_count_ff + 1'b1;
               rsp_in.slot    = dsa_pkg::to_slot(fresh_count_ff[dsa_pkg::IDX_W-1:0]);
               rsp_in.status  = dsa_pkg::ST_FRESH;
            end else begin
               rsp_in.status = dsa_pkg::ST_FULL;
            end
         end
      end
   end

   // Hold pointers and counters; register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         fresh_count_ff <= '0;
         free_head_ff   <= '0;
         free_tail_ff   <= '0;
         free_count_ff  <= '0;
         rsp_ff.valid   <= 1'b0;
      end else begin
         busy_ff        <= 1'b0;
         fresh_count_ff <= fresh_count_in;
         free_head_ff   <= free_head_in;
         free_tail_ff   <= free_tail_in;
         free_count_ff  <= free_count_in;
         rsp_ff.valid   <= rsp_in.valid;
      end
      rsp_ff.slot   <= rsp_in.slot;
      rsp_ff.status <= rsp_in.status;
   end

   assign busy        = busy_ff;
   assign ram_wr_en   = push;
   assign ram_wr_addr = free_tail_ff;
   assign ram_wr_data = req_release_index[dsa_pkg::IDX_W-1:0];
   assign ram_rd_en   = pop;
   assign ram_rd_addr = free_head_ff;
   assign rsp         = rsp_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CountFull)
      else $error("free list count beyond pool size");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_count_ff <= CountFull)
      else $error("fresh counter beyond pool size");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> free_count_ff != '0)
      else $error("pop from empty free list");

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      free_count_ff == '0 |-> free_head_ff == free_tail_ff)
      else $error("empty free list with head and tail apart");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.valid)
      else $error("accepted request without result");

endmodule

// ----- sv/descriptor_slot_allocator.sv -----
// Descriptor slot allocator: hands out slot indices from a fixed pool.
// Request channel: drive the req_ fields with start; a request transfers at
// a rising edge where start is high and busy is low. Release pushes an
// in-range index onto a FIFO free list in a RAM, else reports ignored or
// overflow; allocate returns the resource's existing slot, pops the oldest
// freed one, takes the next never-used one, or reports full or no resource.
// Result channel: rsp_strobe is high for exactly one cycle, the cycle after
// the request transfer, with rsp_slot_index and rsp_status. The result is
// registered to meet the registered free-list RAM read; one request can
// transfer every cycle while busy is low, since pointers and counters update
// at the transfer edge and the next pop reads the already advanced head.
// Reset (synchronous): busy is high while reset is held and drops the cycle
// after; counters and FIFO pointers clear; the free-list RAM is not cleared
// and needs no clearing pass, as an entry is read only after it was pushed.
// The receiver cannot stall: every result must be taken when strobed.
module descriptor_slot_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic                        req_has_resource,
   input  logic                        req_has_existing,
   input  logic [dsa_pkg::SLOT_W-1:0]  req_existing_index,
   input  logic [dsa_pkg::REL_W-1:0]   req_release_index,
   output logic                        rsp_strobe,
   output logic [dsa_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic [2:0]                  rsp_status
);

   logic                       ram_wr_en;
   logic [dsa_pkg::IDX_W-1:0]  ram_wr_addr;
   logic [dsa_pkg::IDX_W-1:0]  ram_wr_data;
   logic                       ram_rd_en;
   logic [dsa_pkg::IDX_W-1:0]  ram_rd_addr;
   logic [dsa_pkg::IDX_W-1:0]  ram_rd_data;
   dsa_pkg::rsp_type           rsp;

   dsa_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_has_resource   (req_has_resource),
      .req_has_existing   (req_has_existing),
      .req_existing_index (req_existing_index),
      .req_release_index  (req_release_index),
      .ram_wr_en          (ram_wr_en),
      .ram_wr_addr        (ram_wr_addr),
      .ram_wr_data        (ram_wr_data),
      .ram_rd_en          (ram_rd_en),
      .ram_rd_addr        (ram_rd_addr),
      .rsp                (rsp)
   );

   dsa_ram #(
      .WIDTH (dsa_pkg::IDX_W),
      .DEPTH (dsa_pkg::SLOT_COUNT)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Select the popped slot from the RAM for free-list grants
   assign rsp_strobe     = rsp.valid;
   assign rsp_status     = rsp.status;
   assign rsp_slot_index = (rsp.status == dsa_pkg::ST_FROM_LIST)
                           ? dsa_pkg::to_slot(ram_rd_data) : rsp.slot;

endmodule
